// File: hw/rtl/i2dt_pkg.sv
// ----------------------------------------------------------------------------
// i2dt_pkg
// Shared types and constants for the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
package i2dt_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    // A 32-bit magnitude never needs more than ten decimal digits.
    localparam int NUM_DIGITS = 10;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DLEFT_W    = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 8'h2D;
    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

    // Operation applied to every digit cell alike.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DOUBLE,
        CELL_SHIFT
    } cell_mode_t;

endpackage

// File: hw/rtl/i2dt_cell.sv
// ----------------------------------------------------------------------------
// i2dt_cell
// One BCD digit cell of the conversion chain.
// ----------------------------------------------------------------------------
module i2dt_cell (
    input  logic                       aclk,
    input  i2dt_pkg::cell_mode_t       mode,
    input  logic                       bit_in,
    input  logic [i2dt_pkg::DIGIT_W-1:0] digit_in,
    output logic                       bit_out,
    output logic [i2dt_pkg::DIGIT_W-1:0] digit_q
);
    import i2dt_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // Add three before doubling so the digit carries correctly in base ten.
    always_comb begin
        adj = (digit_reg >= BCD_ADJ_MIN) ? digit_reg + BCD_ADJ : digit_reg;
        case (mode)
            CELL_CLEAR:  digit_next = '0;
            CELL_DOUBLE: digit_next = {adj[DIGIT_W-2:0], bit_in};
            CELL_SHIFT:  digit_next = digit_in;
            CELL_HOLD:   digit_next = digit_reg;
            default:     digit_next = digit_reg;
        endcase
    end

    assign bit_out = adj[DIGIT_W-1];
    assign digit_q = digit_reg;

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

// File: hw/rtl/signed_int_to_decimal_text_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text_unit
// Converts a signed 32-bit integer into its decimal ASCII characters.
// ----------------------------------------------------------------------------
// Usage: one signed 32-bit value enters per word on the s_ channel. The
// m_ channel returns its decimal text one character per word: a leading '-'
// for negative values, then the digits most significant first without
// leading zeros. Zero gives the single character '0'. m_tlast marks the
// final character of each number.
// Timing: the magnitude is shifted through a row of ten BCD digit cells,
// one bit per cycle. Leading zero digits are then shifted out one per cycle,
// and the remaining digits are shifted out of the top cell one per cycle
// while the receiver is ready. s_tready is high only while no conversion
// is in progress. A finished last character may still wait in the output
// register while the next value is accepted. When the receiver stalls,
// the character in the output register holds and the chain waits. Reset
// (aresetn low at a clock edge) returns the unit to idle and drops any
// pending output word.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic signed [i2dt_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
    // Result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [i2dt_pkg::CHAR_W-1:0]   m_tdata,          // [7:0] text_char
    output logic                          m_tlast           // final character
);
    import i2dt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [VALUE_W-1:0]     mag_reg;
    logic                   neg_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [DLEFT_W-1:0]     dleft_reg;
    logic                   m_tvalid_reg;
    logic [CHAR_W-1:0]      m_tdata_reg;
    logic                   m_tlast_reg;

    cell_mode_t             cell_mode;
    logic                   carry_in [NUM_DIGITS];
    logic [DIGIT_W-1:0]     digit_in [NUM_DIGITS];
    logic [DIGIT_W-1:0]     digit_q  [NUM_DIGITS];
    logic [DIGIT_W-1:0]     top_digit;

    logic                   in_acc;
    logic                   load_out;
    logic                   char_load;
    logic                   skip_zero;
    logic [VALUE_W-1:0]     in_mag;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    // The output register may take a new character when empty or draining.
    assign load_out  = !m_tvalid_reg || m_tready;
    // A new character enters the output register in this cycle.
    assign char_load = load_out &&
                       ((state_reg == ST_SIGN && neg_reg) || (state_reg == ST_EMIT));
    assign top_digit = digit_q[NUM_DIGITS-1];
    // A leading zero is dropped unless it is the only digit left.
    assign skip_zero = (top_digit == '0) && (dleft_reg > DLEFT_W'(1));
    // Unsigned magnitude, so the most negative value converts too.
    assign in_mag    = s_tdata[VALUE_W-1] ? (~s_tdata + VALUE_W'(1)) : s_tdata;

    always_comb begin
        case (state_reg)
            ST_IDLE:    cell_mode = in_acc ? CELL_CLEAR : CELL_HOLD;
            ST_CONVERT: cell_mode = CELL_DOUBLE;
            ST_SKIP:    cell_mode = skip_zero ? CELL_SHIFT : CELL_HOLD;
            ST_EMIT:    cell_mode = load_out ? CELL_SHIFT : CELL_HOLD;
            default:    cell_mode = CELL_HOLD;
        endcase
    end

    // The digit chain: bits enter at the low cell during conversion, and
    // digits move toward the top cell while the text is sent.
    assign carry_in[0] = mag_reg[VALUE_W-1];
    assign digit_in[0] = '0;

    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        if (i < NUM_DIGITS - 1) begin : g_mid
            assign digit_in[i+1] = digit_q[i];
            i2dt_cell u_cell (
                .aclk     (aclk),
                .mode     (cell_mode),
                .bit_in   (carry_in[i]),
                .digit_in (digit_in[i]),
                .bit_out  (carry_in[i+1]),
                .digit_q  (digit_q[i])
            );
        end else begin : g_top
            i2dt_cell u_cell (
                .aclk     (aclk),
                .mode     (cell_mode),
                .bit_in   (carry_in[i]),
                .digit_in (digit_in[i]),
                .bit_out  (),
                .digit_q  (digit_q[i])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            bit_cnt_reg  <= '0;
            dleft_reg    <= '0;
        end else begin
            // A loaded character stays valid until the receiver takes it.
            if (char_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        mag_reg     <= in_mag;
                        neg_reg     <= s_tdata[VALUE_W-1];
                        bit_cnt_reg <= '0;
                        state_reg   <= ST_CONVERT;
                    end
                end
                ST_CONVERT: begin
                    mag_reg     <= {mag_reg[VALUE_W-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
                    if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1)) begin
                        dleft_reg <= DLEFT_W'(NUM_DIGITS);
                        state_reg <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    if (skip_zero) begin
                        dleft_reg <= dleft_reg - DLEFT_W'(1);
                    end else begin
                        state_reg <= ST_SIGN;
                    end
                end
                ST_SIGN: begin
                    if (!neg_reg) begin
                        state_reg <= ST_EMIT;
                    end else if (load_out) begin
                        m_tdata_reg  <= CHAR_MINUS;
                        m_tlast_reg  <= 1'b0;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (load_out) begin
                        m_tdata_reg  <= CHAR_ZERO + CHAR_W'(top_digit);
                        m_tlast_reg  <= (dleft_reg == DLEFT_W'(1));
                        dleft_reg    <= dleft_reg - DLEFT_W'(1);
                        if (dleft_reg == DLEFT_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // An accepted value always starts a fresh 32-step conversion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> (state_reg == ST_CONVERT) && (bit_cnt_reg == '0))
        else $error("conversion did not start after an accepted value");

    // Every digit reaching the top cell after conversion is a valid BCD digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SKIP || state_reg == ST_EMIT) |-> (top_digit <= 4'd9))
        else $error("digit cell holds a non-decimal value");

    // The remaining digit count stays within one to ten while text is sent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SKIP || state_reg == ST_SIGN || state_reg == ST_EMIT)
        |-> (dleft_reg != '0) && (dleft_reg <= DLEFT_W'(NUM_DIGITS)))
        else $error("digit count out of range");

    // Loading the final character of a number returns the unit to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && load_out && dleft_reg == DLEFT_W'(1))
        |=> (state_reg == ST_IDLE) && m_tvalid_reg && m_tlast_reg)
        else $error("last character did not end the conversion");

endmodule
